[rtl/stepper_ramp_phase_sequencer_core_assert.svh]
// ----------------------------------------------------------------------------
// Stepper ramp phase sequencer assertion macros
// Shared macros for the concurrent checks of the sequencer.
// ----------------------------------------------------------------------------
`ifndef STEPPER_RAMP_PHASE_SEQUENCER_CORE_ASSERT_SVH
`define STEPPER_RAMP_PHASE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SRPS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sequencer check failed");

// Next-cycle implication, checked outside reset.
`define SRPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sequencer check failed");

`endif

[rtl/srps_pkg.sv]
// ----------------------------------------------------------------------------
// Stepper ramp phase sequencer package
// Types, codes and constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
package srps_pkg;

   localparam int unsigned REQ_DATA_W  = 16;
   localparam int unsigned RSP_FIELD_W = 195;
   localparam int unsigned RSP_DATA_W  = 200;
   localparam int unsigned TIMING_W    = 30;
   localparam int unsigned STEP_W      = 14;
   localparam int unsigned COUNT_W     = 15;

   localparam logic [31:0]       TIMING_OFFSET = 32'd70000;
   localparam int unsigned       MAX_STEPS     = 8192;
   localparam logic [TIMING_W-1:0] TIMING_RESET = 30'd15000000;

   typedef enum logic [1:0] {
      ACT_START   = 2'd0,
      ACT_ADVANCE = 2'd1,
      ACT_ABORT   = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_ISSUED  = 3'd0,
      ST_NOTHING = 3'd1,
      ST_RANGE   = 3'd2,
      ST_IDLE    = 3'd3,
      ST_ABORTED = 3'd4
   } status_type;

   typedef enum logic {
      REG_STEP_TIMING = 1'b0,
      REG_SWAP_PHASES = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [TIMING_W-1:0] step_timing_ns;
      logic                swap_phases_one_three;
   } cfg_type;

   typedef struct packed {
      logic [3:0]       hold_mask;
      logic [3:0][31:0] phase_slot;
      logic [30:0]      duty_ns;
      logic [31:0]      pwm_period;
      logic             last_cycle;
   } cycle_type;

endpackage

[rtl/stepper_ramp_phase_sequencer_core.sv]
// ----------------------------------------------------------------------------
// Stepper ramp phase sequencer core
// Four-phase stepper sequencer with an acceleration ramp and APB registers.
// ----------------------------------------------------------------------------
// Each request item carries an action in req_tuser (start, advance or abort)
// and a signed step count in req_tdata. Each request gives exactly one
// response item: PWM period, duty, four slot phases and hold mask in
// rsp_tdata, the final step of a move on rsp_tlast, and the status in
// rsp_tuser. The data fields and rsp_tlast are zero when no cycle is issued.
// An item passes an input register and a result register before its
// response is presented; while the receiver is ready, one item is taken
// every cycle, the work being the ramp compares, subtractions and adds.
// When the receiver stalls, the result register holds its item and the
// input register still takes one more item before req_tready falls.
// Reset empties both registers, ends any move and restores the register
// defaults (step timing 15000000 ns, phase swap set). The user must write
// the registers only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "stepper_ramp_phase_sequencer_core_assert.svh"

module stepper_ramp_phase_sequencer_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // step_request[14:0], zero pad
   input  logic [1:0]   req_tuser,   // action[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pwm_period[31:0], duty_ns[62:32], phase_slot0[94:63], phase_slot1[126:95],
   // phase_slot2[158:127], phase_slot3[190:159], hold_mask[194:191], zero pad
   output logic [199:0] rsp_tdata,
   output logic         rsp_tlast,   // last_cycle
   output logic [2:0]   rsp_tuser,   // status[2:0]
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   srps_pkg::cfg_type    cfg;
   srps_pkg::cycle_type  cyc;

   logic                                 in_valid_ff;
   logic                                 in_valid_in;
   srps_pkg::action_type                 in_action_ff;
   logic signed [srps_pkg::COUNT_W-1:0]  in_steps_ff;
   logic                                 out_valid_ff;
   logic                                 out_valid_in;
   logic [srps_pkg::RSP_FIELD_W-1:0]     out_data_ff;
   logic [srps_pkg::RSP_FIELD_W-1:0]     out_data_in;
   logic                                 out_last_ff;
   logic                                 out_last_in;
   srps_pkg::status_type                 out_status_ff;
   srps_pkg::status_type                 out_status_in;

   logic [srps_pkg::STEP_W-1:0] step_index_ff;
   logic [srps_pkg::STEP_W-1:0] step_index_in;
   logic [srps_pkg::STEP_W-1:0] step_total_ff;
   logic [srps_pkg::STEP_W-1:0] step_total_in;
   logic                        move_forward_ff;
   logic                        move_forward_in;
   logic                        moving_ff;
   logic                        moving_in;

   logic                        req_fire;
   logic                        out_free;
   logic                        advance;
   logic                        is_start;
   logic                        steps_neg;
   logic [srps_pkg::COUNT_W-1:0] mag;
   logic                        issue;
   logic [srps_pkg::STEP_W-1:0] calc_step;
   logic [srps_pkg::STEP_W-1:0] calc_total;
   logic                        calc_forward;

   srps_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_action_ff <= srps_pkg::action_type'(req_tuser);
         in_steps_ff  <= signed'(req_tdata[srps_pkg::COUNT_W-1:0]);
      end
   end

   assign is_start  = (in_action_ff == srps_pkg::ACT_START);
   assign steps_neg = in_steps_ff[srps_pkg::COUNT_W-1];
   assign mag       = steps_neg ? srps_pkg::COUNT_W'(-in_steps_ff)
                                : srps_pkg::COUNT_W'(in_steps_ff);

   assign calc_step    = is_start ? '0 : step_index_ff;
   assign calc_total   = is_start ? mag[srps_pkg::STEP_W-1:0] : step_total_ff;
   assign calc_forward = is_start ? !steps_neg : move_forward_ff;

   srps_cycle_calc u_calc (
      .cfg     (cfg),
      .step    (calc_step),
      .total   (calc_total),
      .forward (calc_forward),
      .cyc     (cyc)
   );

   always_comb begin
      step_index_in   = step_index_ff;
      step_total_in   = step_total_ff;
      move_forward_in = move_forward_ff;
      moving_in       = moving_ff;
      issue           = 1'b0;
      out_status_in   = srps_pkg::ST_IDLE;
      unique case (in_action_ff)
         srps_pkg::ACT_START: begin
            if (in_steps_ff == '0) begin
               out_status_in = srps_pkg::ST_NOTHING;
            end else if (32'(mag) > srps_pkg::MAX_STEPS) begin
               out_status_in = srps_pkg::ST_RANGE;
            end else begin
               issue           = 1'b1;
               step_total_in   = mag[srps_pkg::STEP_W-1:0];
               move_forward_in = !steps_neg;
            end
         end
         srps_pkg::ACT_ADVANCE: begin
            issue = moving_ff;
         end
         srps_pkg::ACT_ABORT: begin
            moving_in     = 1'b0;
            out_status_in = srps_pkg::ST_ABORTED;
         end
         default: ;
      endcase
      if (issue) begin
         out_status_in = srps_pkg::ST_ISSUED;
         step_index_in = srps_pkg::STEP_W'(calc_step + 1'b1);
         moving_in     = !cyc.last_cycle;
      end
   end

   assign out_data_in = issue ? {cyc.hold_mask, cyc.phase_slot, cyc.duty_ns, cyc.pwm_period}
                              : '0;
   assign out_last_in = issue && cyc.last_cycle;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff    <= 1'b0;
         step_index_ff   <= '0;
         step_total_ff   <= '0;
         move_forward_ff <= 1'b0;
         moving_ff       <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            step_index_ff   <= step_index_in;
            step_total_ff   <= step_total_in;
            move_forward_ff <= move_forward_in;
            moving_ff       <= moving_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff   <= out_data_in;
         out_last_ff   <= out_last_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_data_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_status_ff;

   `SRPS_ASSERT_IMPLIES(a_no_cycle_zero, clock, reset,
      rsp_tvalid && (out_status_ff != srps_pkg::ST_ISSUED),
      (rsp_tdata == '0) && !rsp_tlast)
   `SRPS_ASSERT_IMPLIES(a_index_in_move, clock, reset,
      moving_ff && (step_total_ff != '0), step_index_ff < step_total_ff)
   `SRPS_ASSERT_NEXT(a_last_ends_move, clock, reset,
      advance && issue && cyc.last_cycle, !moving_ff)
   `SRPS_ASSERT_NEXT(a_abort_ends_move, clock, reset,
      advance && (in_action_ff == srps_pkg::ACT_ABORT), !moving_ff)
   `SRPS_ASSERT_IMPLIES(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)

endmodule

[rtl/srps_csr.sv]
// ----------------------------------------------------------------------------
// Stepper ramp phase sequencer register bank
// APB-style access to the step timing and phase swap registers.
// ----------------------------------------------------------------------------
module srps_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output srps_pkg::cfg_type cfg
);

   logic [srps_pkg::TIMING_W-1:0] timing_ff;
   logic [srps_pkg::TIMING_W-1:0] timing_in;
   logic                          swap_ff;
   logic                          swap_in;
   logic                          wr_en;
   srps_pkg::reg_index_type       reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = srps_pkg::reg_index_type'(csr_paddr[2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      timing_in = timing_ff;
      swap_in   = swap_ff;
      if (wr_en) begin
         unique case (reg_sel)
            srps_pkg::REG_STEP_TIMING: timing_in = csr_pwdata[srps_pkg::TIMING_W-1:0];
            srps_pkg::REG_SWAP_PHASES: swap_in   = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff <= srps_pkg::TIMING_RESET;
         swap_ff   <= 1'b1;
      end else begin
         timing_ff <= timing_in;
         swap_ff   <= swap_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         srps_pkg::REG_STEP_TIMING: csr_prdata = {2'b00, timing_ff};
         srps_pkg::REG_SWAP_PHASES: csr_prdata = {31'd0, swap_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   assign cfg.step_timing_ns        = timing_ff;
   assign cfg.swap_phases_one_three = swap_ff;

endmodule

[rtl/srps_cycle_calc.sv]
// ----------------------------------------------------------------------------
// Stepper ramp phase sequencer cycle calculation
// Ramp period, duty, slot phases and hold flags for one step.
// ----------------------------------------------------------------------------
module srps_cycle_calc (
   input  srps_pkg::cfg_type          cfg,
   input  logic [srps_pkg::STEP_W-1:0] step,
   input  logic [srps_pkg::STEP_W-1:0] total,
   input  logic                       forward,
   output srps_pkg::cycle_type        cyc
);

   logic signed [15:0] step_s;
   logic signed [15:0] total_s;
   logic               ramp_outer;
   logic               ramp_inner;
   logic               terminal;
   logic [31:0]        base;
   logic [31:0]        period;
   logic [31:0]        quarter;
   logic [31:0]        three_q;
   logic [1:0]         half_rem;
   logic               hold_top;
   logic [3:0][31:0]   ph;
   logic [3:0]         hold;

   assign step_s  = signed'({2'b00, step});
   assign total_s = signed'({2'b00, total});

   assign ramp_outer = (step_s < 16'sd2) || (step_s >= total_s - 16'sd2);
   assign ramp_inner = (step_s < 16'sd4) || (step_s >= total_s - 16'sd5);
   assign terminal   = (step_s == total_s - 16'sd1);

   assign base = {2'b00, cfg.step_timing_ns} - srps_pkg::TIMING_OFFSET;

   always_comb begin
      priority if (ramp_outer) begin
         period = {base[29:0], 2'b00};
      end else if (ramp_inner) begin
         period = {base[30:0], 1'b0};
      end else begin
         period = base;
      end
   end

   assign quarter = {2'b00, period[31:2]};
   assign three_q = {quarter[30:0], 1'b0} + quarter;

   // Only the slot at three quarters can overrun: with period = 4q + r the
   // test reduces to q > ceil(r / 2).
   assign half_rem = {period[1] & period[0], period[1] ^ period[0]};
   assign hold_top = quarter > {30'd0, half_rem};

   always_comb begin
      if (forward) begin
         ph   = {three_q, {quarter[30:0], 1'b0}, quarter, 32'd0};
         hold = {hold_top, 3'b000};
      end else begin
         ph   = {32'd0, quarter, {quarter[30:0], 1'b0}, three_q};
         hold = {3'b000, hold_top};
      end
      if (cfg.swap_phases_one_three) begin
         ph   = {ph[1], ph[2], ph[3], ph[0]};
         hold = {hold[1], hold[2], hold[3], hold[0]};
      end
   end

   assign cyc.pwm_period = period;
   assign cyc.duty_ns    = period[31:1];
   assign cyc.phase_slot = ph;
   assign cyc.hold_mask  = terminal ? 4'd0 : hold;
   assign cyc.last_cycle = terminal;

endmodule

[tb/stepper_ramp_phase_sequencer_core_test.sv]
// ----------------------------------------------------------------------------
// Stepper ramp phase sequencer core testbench
// Drives move, advance and abort items through the request stream and
// predicts every response from a local model of the ramp, the quarter phases
// and the hold mask. Responses are checked field by field in order, while
// the request side sends in bursts and the response side stalls. Several
// timing and phase-swap settings are written over the register port.
// ----------------------------------------------------------------------------
module stepper_ramp_phase_sequencer_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACT_RESERVED = 2'd3;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam int         PHASE_ITEMS  = 210;

   typedef struct packed {
      logic [1:0]  act;
      logic [14:0] steps;
   } motion_cmd_type;

   typedef struct packed {
      logic [31:0]          period;
      logic [30:0]          duty;
      logic [3:0][31:0]     phase;
      logic [3:0]           hold;
      logic                 last;
      srps_pkg::status_type status;
   } pwm_cycle_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [15:0]  req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [199:0] rsp_tdata;
   logic         rsp_tlast;
   logic [2:0]   rsp_tuser;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   motion_cmd_type cmd_queue[$];
   pwm_cycle_type  expected_cycles[$];
   motion_cmd_type next_cmd;
   logic           req_fire = 1'b0;
   int             burst_left = 0;
   int             gap_left = 0;
   int             stall_mode = 0;
   int             ready_cycle = 0;
   int             cycle_count = 0;
   int             error_count = 0;

   // Local copy of the block's registers and move state.
   logic [srps_pkg::TIMING_W-1:0] timing_ns = srps_pkg::TIMING_RESET;
   logic                          swap_slots = 1'b1;
   logic [srps_pkg::STEP_W-1:0]   step_no = '0;
   logic [srps_pkg::STEP_W-1:0]   step_count = '0;
   logic                          forward = 1'b0;
   logic                          running = 1'b0;

   stepper_ramp_phase_sequencer_core u_top (.*);

   always #5 clock = ~clock;

   function automatic pwm_cycle_type emit_step_cycle();
      pwm_cycle_type c;
      int            s;
      int            t;
      logic          terminal;
      logic [31:0]   base;
      logic [31:0]   period;
      logic [31:0]   quarter;
      logic [31:0]   duty;
      logic [31:0]   k;
      logic [31:0]   ph[4];
      logic [32:0]   reach;
      int            src;
      c = '0;
      s = int'(step_no);
      t = int'(step_count);
      terminal = (s == t - 1);
      base = {2'b00, timing_ns} - srps_pkg::TIMING_OFFSET;
      if (s < 2 || s >= t - 2) begin
         period = base << 2;
      end else if (s < 4 || s >= t - 5) begin
         period = base << 1;
      end else begin
         period = base;
      end
      quarter = period >> 2;
      duty = period >> 1;
      for (int i = 0; i < 4; i++) begin
         k = forward ? i : 3 - i;
         ph[i] = k * quarter;
      end
      for (int i = 0; i < 4; i++) begin
         src = (swap_slots && (i == 1 || i == 3)) ? 4 - i : i;
         c.phase[i] = ph[src];
         reach = ph[src] + duty;
         if (!terminal && reach > {1'b0, period}) c.hold[i] = 1'b1;
      end
      c.period = period;
      c.duty = duty[30:0];
      c.last = terminal;
      c.status = srps_pkg::ST_ISSUED;
      step_no = step_no + 1'b1;
      if (terminal) running = 1'b0;
      return c;
   endfunction

   function automatic pwm_cycle_type predict_motion(logic [1:0] act, logic [14:0] raw);
      pwm_cycle_type c;
      int            steps;
      int            mag;
      c = '0;
      c.status = srps_pkg::ST_IDLE;
      steps = int'($signed(raw));
      mag = steps < 0 ? -steps : steps;
      case (act)
         srps_pkg::ACT_START: begin
            if (steps == 0) begin
               c.status = srps_pkg::ST_NOTHING;
            end else if (mag > srps_pkg::MAX_STEPS) begin
               c.status = srps_pkg::ST_RANGE;
            end else begin
               step_count = mag[srps_pkg::STEP_W-1:0];
               forward = steps > 0;
               step_no = '0;
               running = 1'b1;
               c = emit_step_cycle();
            end
         end
         srps_pkg::ACT_ADVANCE: begin
            if (running) c = emit_step_cycle();
         end
         srps_pkg::ACT_ABORT: begin
            running = 1'b0;
            c.status = srps_pkg::ST_ABORTED;
         end
         default: ;
      endcase
      return c;
   endfunction

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         error_count++;
         if (error_count <= 10)
            $display("Mismatch on %s: expected %h, got %h", name, want, got);
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (cmd_queue.size() > 0) begin
            next_cmd = cmd_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {1'b0, next_cmd.steps};
            req_tuser <= next_cmd.act;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      ready_cycle++;
      if (ready_cycle % 200 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 99) < 60);
         2: rsp_tready <= ((ready_cycle % 7) >= 3);
         default: rsp_tready <= ($urandom_range(0, 99) < 92);
      endcase
   end

   always @(posedge clock) begin
      pwm_cycle_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         req_fire <= req_tvalid && req_tready && !reset;
         if (!reset) begin
            if (req_tvalid && req_tready)
               expected_cycles.push_back(predict_motion(req_tuser, req_tdata[14:0]));
            if (rsp_tvalid && rsp_tready) begin
               if (expected_cycles.size() == 0) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("Unexpected response item: status %0d", rsp_tuser);
               end else begin
                  want = expected_cycles.pop_front();
                  check_field("pwm_period", rsp_tdata[31:0], want.period);
                  check_field("duty_ns", {1'b0, rsp_tdata[62:32]}, {1'b0, want.duty});
                  check_field("phase_slot0", rsp_tdata[94:63], want.phase[0]);
                  check_field("phase_slot1", rsp_tdata[126:95], want.phase[1]);
                  check_field("phase_slot2", rsp_tdata[158:127], want.phase[2]);
                  check_field("phase_slot3", rsp_tdata[190:159], want.phase[3]);
                  check_field("hold_mask", {28'b0, rsp_tdata[194:191]}, {28'b0, want.hold});
                  check_field("last_cycle", {31'b0, rsp_tlast}, {31'b0, want.last});
                  check_field("status", {29'b0, rsp_tuser}, {29'b0, want.status});
               end
            end
         end
      end
   end

   task automatic push_cmd(logic [1:0] act, int steps);
      motion_cmd_type c;
      c.act = act;
      c.steps = 15'(steps);
      cmd_queue.push_back(c);
   endtask

   task automatic csr_write(srps_pkg::reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == srps_pkg::REG_STEP_TIMING) timing_ns = value[srps_pkg::TIMING_W-1:0];
      else swap_slots = value[0];
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (cmd_queue.size() != 0 || req_tvalid || expected_cycles.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic queue_moves(int total_items);
      int start_size;
      int n;
      int k;
      int r;
      start_size = cmd_queue.size();
      while (cmd_queue.size() - start_size < total_items) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            r = $urandom_range(0, 99);
            n = (r < 70) ? $urandom_range(1, 8) :
                (r < 95) ? $urandom_range(9, 40) : $urandom_range(41, 200);
            push_cmd(srps_pkg::ACT_START, $urandom_range(0, 1) ? n : -n);
            if ($urandom_range(0, 99) < 80) begin
               for (int i = 1; i < n; i++) push_cmd(srps_pkg::ACT_ADVANCE, $urandom);
               k = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
               for (int i = 0; i < k; i++) push_cmd(srps_pkg::ACT_ADVANCE, $urandom);
            end else begin
               k = $urandom_range(0, n - 1);
               for (int i = 0; i < k; i++) push_cmd(srps_pkg::ACT_ADVANCE, $urandom);
               if ($urandom_range(0, 1)) push_cmd(srps_pkg::ACT_ABORT, $urandom);
            end
         end else begin
            case ($urandom_range(0, 4))
               0: push_cmd(srps_pkg::ACT_START, $urandom);
               1: push_cmd(srps_pkg::ACT_START,
                           $urandom_range(0, 1) ? 8192 + $urandom_range(0, 1)
                                                : -8192 - $urandom_range(0, 1));
               2: push_cmd(srps_pkg::ACT_ADVANCE, $urandom);
               3: push_cmd(srps_pkg::ACT_ABORT, $urandom);
               default: push_cmd(ACT_RESERVED, $urandom);
            endcase
         end
      end
   endtask

   initial begin
      logic [31:0] timing_set[8];
      timing_set = '{32'd71000, 32'd1000000000, 32'h3FFFFFFF, 32'd0,
                     32'd70000, 32'd69999, 32'd0, 32'd0};
      timing_set[6] = $urandom_range(71000, 1000000000);
      timing_set[7] = {2'b00, 30'($urandom)};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_cmd(srps_pkg::ACT_START, 0);
      push_cmd(srps_pkg::ACT_START, 8193);
      push_cmd(srps_pkg::ACT_START, -8193);
      push_cmd(srps_pkg::ACT_START, 16383);
      push_cmd(srps_pkg::ACT_START, -16384);
      push_cmd(srps_pkg::ACT_ADVANCE, 0);
      push_cmd(srps_pkg::ACT_ABORT, 0);
      push_cmd(ACT_RESERVED, 0);
      push_cmd(srps_pkg::ACT_START, 8192);
      push_cmd(srps_pkg::ACT_ADVANCE, 0);
      push_cmd(srps_pkg::ACT_ABORT, 0);
      push_cmd(srps_pkg::ACT_START, -8192);
      push_cmd(srps_pkg::ACT_START, 1);
      push_cmd(srps_pkg::ACT_ADVANCE, 0);
      push_cmd(srps_pkg::ACT_START, 7);
      for (int i = 0; i < 6; i++) push_cmd(srps_pkg::ACT_ADVANCE, 16383);
      push_cmd(srps_pkg::ACT_START, -3);
      push_cmd(ACT_RESERVED, -1);
      push_cmd(srps_pkg::ACT_START, 2);
      push_cmd(srps_pkg::ACT_ADVANCE, -16384);
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         csr_write(srps_pkg::REG_STEP_TIMING, timing_set[p]);
         csr_write(srps_pkg::REG_SWAP_PHASES, {31'b0, p[0]});
         queue_moves(PHASE_ITEMS);
         wait_idle();
      end

      if (expected_cycles.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
